// ===== design/nalsplit_pkg.sv =====
// Shared types and constants for the Annex B unit splitter.
package nalsplit_pkg;

  // Byte values that the start code detector looks for
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] StartByte = 8'h01;

  // Held-back zero run saturates at this count
  localparam logic [1:0] ZeroRunMax = 2'd3;

  // Header byte field positions
  localparam int unsigned RefIdcLsb = 5;

  // One input beat
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } item_t;

  // One unit descriptor
  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_length;
    logic [1:0]  ref_idc;
    logic [4:0]  unit_type;
  } desc_t;

  // Handshake between the input register and the parser
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

endpackage

// ===== design/nalsplit_if.sv =====
// Stream interfaces for the byte input and the descriptor output.
interface nalsplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface nalsplit_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_offset;
  logic [31:0] unit_length;
  logic [1:0]  ref_idc;
  logic [4:0]  unit_type;

  modport source (output valid, output unit_offset, output unit_length, output ref_idc,
                  output unit_type, input ready);
  modport sink (input valid, input unit_offset, input unit_length, input ref_idc,
                input unit_type, output ready);
endinterface

// ===== design/nalsplit_in_reg.sv =====
// Input register stage that holds one accepted byte beat.
module nalsplit_in_reg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  nalsplit_pkg::item_t          item_i,
  output logic                         ready_o,
  input  logic                         advance_i,
  output nalsplit_pkg::stage_ctrl_t    ctrl_o,
  output nalsplit_pkg::item_t          item_o
);
  import nalsplit_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // Take a new beat when empty or when the held beat moves on
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance_i;
  assign item_o         = item_q;

endmodule

// ===== design/nalsplit_core.sv =====
// Start code parser: unit state, counters and descriptor build.
module nalsplit_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nalsplit_pkg::stage_ctrl_t ctrl_i,
  input  nalsplit_pkg::item_t       item_i,
  output logic                      emit_o,
  output nalsplit_pkg::desc_t       desc_o
);
  import nalsplit_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  // Parser state
  logic          inside_q, inside_d;
  logic [1:0]    zr_q, zr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] start_q, start_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [6:0]    hdr_q, hdr_d;

  logic          is_sc;
  logic [2:0]    add_amt;
  logic [CW:0]   cnt_sum;
  logic [CW-1:0] cnt_sat;
  logic [CW-1:0] pos_inc;
  logic [6:0]    hdr_byte;
  logic [6:0]    hdr_zero;
  logic [CW-1:0] start_sel, cnt_sel;
  logic [6:0]    hdr_sel;
  logic [31:0]   off32, len32;

  // Start code: a 01 byte after at least two held zeros
  assign is_sc = (item_i.stream_byte == StartByte) && zr_q[1];

  // Saturating counter updates
  assign cnt_sum = {1'b0, cnt_q} + (CW+1)'(add_amt);
  assign cnt_sat = cnt_sum[CW] ? '1 : cnt_sum[CW-1:0];
  assign pos_inc = (&pos_q) ? pos_q : pos_q + CW'(1);

  // Header once held zeros and this byte are committed
  assign hdr_byte = (cnt_q != '0) ? hdr_q :
                    ((zr_q != 2'd0) ? 7'd0 : item_i.stream_byte[6:0]);
  // Header once a single zero is committed
  assign hdr_zero = (cnt_q != '0) ? hdr_q : 7'd0;

  always_comb begin
    inside_d  = inside_q;
    zr_d      = zr_q;
    start_d   = start_q;
    cnt_d     = cnt_q;
    hdr_d     = hdr_q;
    pos_d     = pos_inc;
    add_amt   = 3'd0;
    emit_o    = 1'b0;
    start_sel = start_q;
    cnt_sel   = cnt_q;
    hdr_sel   = hdr_q;
    if (is_sc) begin
      // Close the open unit and open a new one after this byte
      emit_o   = inside_q && (cnt_q != '0);
      inside_d = 1'b1;
      start_d  = pos_inc;
      cnt_d    = '0;
      hdr_d    = 7'd0;
      zr_d     = 2'd0;
    end else if (item_i.end_of_stream) begin
      // Flush held zeros and the final byte into the unit
      add_amt = {1'b0, zr_q} + 3'd1;
      if (inside_q) begin
        emit_o  = 1'b1;
        cnt_sel = cnt_sat;
        hdr_sel = hdr_byte;
      end
    end else if (item_i.stream_byte == ZeroByte) begin
      if (zr_q == ZeroRunMax) begin
        // Commit the oldest held zero
        add_amt = 3'd1;
        if (inside_q) begin
          cnt_d = cnt_sat;
          hdr_d = hdr_zero;
        end
      end else begin
        zr_d = zr_q + 2'd1;
      end
    end else begin
      // Ordinary byte: commit held zeros and the byte
      add_amt = {1'b0, zr_q} + 3'd1;
      if (inside_q) begin
        cnt_d = cnt_sat;
        hdr_d = hdr_byte;
      end
      zr_d = 2'd0;
    end
    // Return to reset after the final byte
    if (item_i.end_of_stream) begin
      inside_d = 1'b0;
      zr_d     = 2'd0;
      pos_d    = '0;
      start_d  = '0;
      cnt_d    = '0;
      hdr_d    = 7'd0;
    end
  end

  // Narrow counters to the 32-bit descriptor fields
  if (CW > 32) begin : g_sat
    assign off32 = (|start_sel[CW-1:32]) ? '1 : start_sel[31:0];
    assign len32 = (|cnt_sel[CW-1:32]) ? '1 : cnt_sel[31:0];
  end else begin : g_ext
    assign off32 = 32'(start_sel);
    assign len32 = 32'(cnt_sel);
  end

  assign desc_o.unit_offset = off32;
  assign desc_o.unit_length = len32;
  assign desc_o.ref_idc     = hdr_sel[RefIdcLsb+1:RefIdcLsb];
  assign desc_o.unit_type   = hdr_sel[RefIdcLsb-1:0];

  // Advance state once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      zr_q     <= 2'd0;
      pos_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      hdr_q    <= 7'd0;
    end else if (ctrl_i.advance) begin
      inside_q <= inside_d;
      zr_q     <= zr_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      hdr_q    <= hdr_d;
    end
  end

  // A final byte leaves the parser in its reset state
  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && item_i.end_of_stream |=> !inside_q && (pos_q == '0) && (zr_q == 2'd0))
    else $error("parser state not cleared after final byte");

  // Outside a unit nothing is counted
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inside_q |-> (cnt_q == '0))
    else $error("bytes counted outside a unit");

endmodule

// ===== design/annex_b_nal_unit_splitter_unit.sv =====
// Annex B unit splitter top level: input register, parser and descriptor register.
//
// Takes an Annex B byte stream one byte per beat, with end_of_stream on the final
// byte, and returns one descriptor (offset, length, ref_idc, type) for each
// non-empty unit between start codes. A byte is accepted every cycle while the
// descriptor side keeps up; a descriptor is loaded into the descriptor register
// from the parser once the byte that closes its unit leaves the input register.
// The rate is set by the parser state, which is updated once per byte. Counters
// are COUNT_WIDTH bits wide and saturate; offsets and lengths above 32 bits read as all ones.
module annex_b_nal_unit_splitter_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  nalsplit_in_if.sink           bs_i,
  nalsplit_out_if.source        desc_o
);
  import nalsplit_pkg::*;

  stage_ctrl_t ctrl;
  item_t       in_item, s1_item;
  logic        advance;
  logic        emit;
  desc_t       desc;
  logic        out_valid_q, out_valid_d;
  desc_t       desc_q;

  assign in_item.stream_byte   = bs_i.stream_byte;
  assign in_item.end_of_stream = bs_i.end_of_stream;

  // Input register stage
  nalsplit_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (bs_i.valid),
    .item_i    (in_item),
    .ready_o   (bs_i.ready),
    .advance_i (advance),
    .ctrl_o    (ctrl),
    .item_o    (s1_item)
  );

  // Move a held beat on when the descriptor register is free or draining
  assign advance = ctrl.valid && (!out_valid_q || desc_o.ready);

  nalsplit_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .item_i (s1_item),
    .emit_o (emit),
    .desc_o (desc)
  );

  // Descriptor register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (desc_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      desc_q <= desc;
    end
  end

  assign desc_o.valid       = out_valid_q;
  assign desc_o.unit_offset = desc_q.unit_offset;
  assign desc_o.unit_length = desc_q.unit_length;
  assign desc_o.ref_idc     = desc_q.ref_idc;
  assign desc_o.unit_type   = desc_q.unit_type;

  // Input stalls only behind a held beat and a blocked descriptor
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bs_i.ready |-> (ctrl.valid && out_valid_q && !desc_o.ready))
    else $error("input stalled without a blocked descriptor");

  // Emitted units are never empty
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_o.valid |-> (desc_o.unit_length != 32'd0))
    else $error("empty unit emitted");

  // A blocked descriptor keeps the parser from advancing
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !desc_o.ready |-> !advance)
    else $error("parser advanced over a pending descriptor");

endmodule

// ===== tb/tb_annex_b_nal_unit_splitter_unit.sv =====
// Testbench for the Annex B unit splitter: byte streams checked against a local start code parser.
module tb_annex_b_nal_unit_splitter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import nalsplit_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 450;
  localparam int unsigned CalmTail    = 60;

  // One queued byte; drain holds it back until every due descriptor has come
  typedef struct {
    item_t item;
    bit    drain;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  nalsplit_in_if  bs_if ();
  nalsplit_out_if desc_if ();

  annex_b_nal_unit_splitter_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bs_i   (bs_if),
    .desc_o (desc_if)
  );

  beat_t       pending[$];
  desc_t       units_due[$];
  bit          hold_next = 1'b0;
  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  int unsigned gap_left;
  int unsigned stall_left;
  logic        calm;

  // Parser state
  bit          in_unit    = 1'b0;
  logic [1:0]  zero_run   = '0;
  logic [31:0] byte_pos   = '0;
  logic [31:0] unit_first = '0;
  logic [31:0] unit_len   = '0;
  logic [7:0]  head       = '0;

  assign calm = (pending.size() < CalmTail);

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] n);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, n};
    return sum[32] ? '1 : sum[31:0];
  endfunction

  function automatic void add_zeros(logic [31:0] n);
    if (n == 0) return;
    if (unit_len == 0) head = ZeroByte;
    unit_len = sat_add(unit_len, n);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    if (unit_len == 0) head = b;
    unit_len = sat_add(unit_len, 32'd1);
  endfunction

  // Queue a descriptor for the open unit unless it is empty
  function automatic void close_unit();
    desc_t d;
    if (unit_len == 0) return;
    d.unit_offset = unit_first;
    d.unit_length = unit_len;
    d.ref_idc     = head[RefIdcLsb +: 2];
    d.unit_type   = head[RefIdcLsb-1:0];
    units_due = {units_due, d};
  endfunction

  // Advance the parser by one accepted byte
  function automatic void split_byte(item_t it);
    if (it.stream_byte == StartByte && zero_run >= 2'd2) begin
      if (in_unit) close_unit();
      in_unit    = 1'b1;
      unit_first = sat_add(byte_pos, 32'd1);
      unit_len   = '0;
      head       = '0;
      zero_run   = '0;
    end else if (it.end_of_stream) begin
      if (in_unit) begin
        add_zeros(32'(zero_run));
        add_byte(it.stream_byte);
        close_unit();
      end
    end else if (it.stream_byte == ZeroByte) begin
      if (zero_run >= ZeroRunMax) begin
        if (in_unit) add_zeros(32'd1);
        zero_run = ZeroRunMax;
      end else begin
        zero_run = zero_run + 2'd1;
      end
    end else begin
      if (in_unit) begin
        add_zeros(32'(zero_run));
        add_byte(it.stream_byte);
      end
      zero_run = '0;
    end
    byte_pos = sat_add(byte_pos, 32'd1);
    // The final byte returns everything to reset
    if (it.end_of_stream) begin
      in_unit    = 1'b0;
      zero_run   = '0;
      byte_pos   = '0;
      unit_first = '0;
      unit_len   = '0;
      head       = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic add_beat(input logic [7:0] b, input logic eos);
    beat_t bt;
    bt.item.stream_byte   = b;
    bt.item.end_of_stream = eos;
    bt.drain              = hold_next;
    hold_next             = 1'b0;
    pending = {pending, bt};
  endtask

  task automatic add_start_code(input int unsigned zeros);
    repeat (zeros) add_beat(ZeroByte, 1'b0);
    add_beat(StartByte, 1'b0);
  endtask

  function automatic logic [7:0] body_byte();
    return ($urandom_range(0, 3) == 0) ? ZeroByte : 8'($urandom);
  endfunction

  // One random stream: mostly well-formed units, sometimes plain noise
  task automatic add_random_stream();
    int unsigned units;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 3) == 0) add_beat(StartByte, 1'b0);
        else add_beat(($urandom_range(0, 1) == 0) ? ZeroByte : 8'($urandom), 1'b0);
      end
    end else begin
      repeat ($urandom_range(0, 2)) add_beat(8'($urandom), 1'b0);
      units = $urandom_range(1, 4);
      repeat (units) begin
        add_start_code(($urandom_range(0, 3) == 0) ? $urandom_range(3, 6) : 2);
        if ($urandom_range(0, 9) != 0) begin
          add_beat(($urandom_range(0, 7) == 0) ? ZeroByte : 8'($urandom), 1'b0);
          repeat ($urandom_range(0, 6)) add_beat(body_byte(), 1'b0);
        end
      end
      // Close either on a start code or on an ordinary byte
      if ($urandom_range(0, 5) == 0) add_start_code(2);
      else add_beat(body_byte(), 1'b0);
    end
    pending[pending.size()-1].item.end_of_stream = 1'b1;
  endtask

  // Byte driver: present queued beats, with idle bursts and a drain pause
  always @(posedge clk_i or negedge rst_ni) begin : driver
    beat_t nxt;
    item_t took;
    if (!rst_ni) begin
      bs_if.valid         <= 1'b0;
      bs_if.stream_byte   <= '0;
      bs_if.end_of_stream <= 1'b0;
      gap_left            <= 0;
    end else begin
      if (bs_if.valid && bs_if.ready) begin
        took.stream_byte   = bs_if.stream_byte;
        took.end_of_stream = bs_if.end_of_stream;
        split_byte(took);
      end
      if (!bs_if.valid || bs_if.ready) begin
        if (gap_left != 0) begin
          bs_if.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending.size() == 0) begin
          bs_if.valid <= 1'b0;
        end else if (pending[0].drain && units_due.size() != 0) begin
          bs_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          bs_if.valid <= 1'b0;
          gap_left    <= $urandom_range(0, 6);
        end else begin
          nxt = pending.pop_front();
          bs_if.valid         <= 1'b1;
          bs_if.stream_byte   <= nxt.item.stream_byte;
          bs_if.end_of_stream <= nxt.item.end_of_stream;
        end
      end
    end
  end

  // Descriptor monitor: check each beat against the oldest due descriptor
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    desc_t want;
    if (!rst_ni) begin
      desc_if.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (desc_if.valid && desc_if.ready) begin
        if (units_due.size() == 0) begin
          report_mismatch("descriptor with none due, offset", desc_if.unit_offset, '0);
        end else begin
          want = units_due.pop_front();
          if (desc_if.unit_offset !== want.unit_offset)
            report_mismatch("unit_offset", desc_if.unit_offset, want.unit_offset);
          if (desc_if.unit_length !== want.unit_length)
            report_mismatch("unit_length", desc_if.unit_length, want.unit_length);
          if (desc_if.ref_idc !== want.ref_idc)
            report_mismatch("ref_idc", 32'(desc_if.ref_idc), 32'(want.ref_idc));
          if (desc_if.unit_type !== want.unit_type)
            report_mismatch("unit_type", 32'(desc_if.unit_type), 32'(want.unit_type));
        end
      end
      if (calm) begin
        desc_if.ready <= 1'b1;
        stall_left    <= 0;
      end else if (stall_left != 0) begin
        desc_if.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
        desc_if.ready <= 1'b0;
        stall_left    <= $urandom_range(0, 6);
      end else begin
        desc_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_annex_b_nal_unit_splitter_unit: errors");
      $finish;
    end
  end

  initial begin
    int unsigned directed;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    bs_if.valid         = 1'b0;
    bs_if.stream_byte   = '0;
    bs_if.end_of_stream = 1'b0;
    desc_if.ready       = 1'b0;

    // Final byte before any start code: nothing comes out
    add_beat(8'h12, 1'b1);
    // Three-byte start, lone zero before 01, long zero run closing on a
    // four-byte start with two zeros kept
    add_start_code(2);
    add_beat(8'hE7, 1'b0);
    add_start_code(1);
    add_start_code(5);
    // Unit whose first committed byte is a zero from a long run
    repeat (4) add_beat(ZeroByte, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_start_code(3);
    // Start code as final byte, after a pause for all due descriptors
    hold_next = 1'b1;
    add_beat(ZeroByte, 1'b0);
    add_beat(ZeroByte, 1'b0);
    add_beat(StartByte, 1'b1);

    directed  = pending.size();
    hold_next = 1'b1;
    while (pending.size() - directed < RandomBytes) add_random_stream();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || bs_if.valid) @(posedge clk_i);
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_annex_b_nal_unit_splitter_unit: clean");
    end else begin
      $display("tb_annex_b_nal_unit_splitter_unit: errors");
    end
    $finish;
  end

endmodule
